/* hdl/csit_pkg.sv */
// Package for the circle versus segment intersection test.
// Holds the default coordinate width and the case flags carried down the pipeline.
// No dependencies.
package csit_pkg;

    // Default width of one signed coordinate.
    localparam int CSIT_COORD_BITS = 16;

    // Which test decides the answer, and the answer of the end point test.
    typedef struct packed {
        logic interior;   // closest point lies strictly inside the segment
        logic end_hit;    // nearest end point lies in the closed disc
    } t_case;

endpackage

/* hdl/circle_segment_intersect_test_unit.sv */
// Circle versus line segment intersection test, seven stage pipeline.
// Depends on csit_pkg (default width, case flag struct).
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------------------
//   input    | i_in_valid / o_in_ready    | i_center_x/y, i_radius, i_start_x/y, i_end_x/y
//   output   | o_out_valid / i_out_ready  | o_hit
//
// One beat is accepted per cycle unless the output stalls; each result passes through
// the chain subtract, multiply, sum, classify, partial products, partial product sum
// and final compare, one register stage each.
// All stages share one enable: while a result waits at the output and is not taken,
// the whole pipeline holds, so nothing is lost or repeated.
// Reset (synchronous, active low) clears the stage valid bits only.
module circle_segment_intersect_test_unit
    import csit_pkg::*;
#(
    parameter int COORD_BITS = CSIT_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic        [COORD_BITS-2:0] i_radius,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_hit
);

    localparam int W   = COORD_BITS;
    localparam int DW  = W + 1;          // coordinate difference
    localparam int PW  = 2 * W + 2;      // product of two differences
    localparam int SW  = 2 * W + 3;      // dot and cross products
    localparam int MW  = 2 * W + 2;      // squared lengths, cross magnitude
    localparam int K   = W + 1;          // half of the cross magnitude
    localparam int RW  = W - 1;          // radius, and half of its square
    localparam int R2W = 2 * W - 2;      // squared radius
    localparam int PPW = 2 * K;          // cross magnitude partial product
    localparam int RPW = RW + K;         // radius times length partial product
    localparam int QW  = 4 * W + 4;      // final comparison width
    localparam int NST = 7;

    logic [NST-1:0] r_v;
    logic           w_en;

    // The whole pipeline moves when the output stage is empty or is being taken.
    assign w_en        = i_out_ready || !r_v[NST-1];
    assign o_in_ready  = w_en;
    assign o_out_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NST-2:0], i_in_valid};
        end
    end

    // Stage 1: differences. d = end - start, w = center - start, e = center - end.
    logic signed [DW-1:0] r1_dx, r1_dy, r1_wx, r1_wy, r1_ex, r1_ey;
    logic        [RW-1:0] r1_r;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx <= {i_end_x[W-1], i_end_x} - {i_start_x[W-1], i_start_x};
            r1_dy <= {i_end_y[W-1], i_end_y} - {i_start_y[W-1], i_start_y};
            r1_wx <= {i_center_x[W-1], i_center_x} - {i_start_x[W-1], i_start_x};
            r1_wy <= {i_center_y[W-1], i_center_y} - {i_start_y[W-1], i_start_y};
            r1_ex <= {i_center_x[W-1], i_center_x} - {i_end_x[W-1], i_end_x};
            r1_ey <= {i_center_y[W-1], i_center_y} - {i_end_y[W-1], i_end_y};
            r1_r  <= i_radius;
        end
    end

    // Stage 2: the products of two differences that later stages need, plus the squared radius.
    logic signed [PW-1:0]  r2_dxx, r2_dyy, r2_wxdx, r2_wydy, r2_wxdy, r2_wydx;
    logic signed [PW-1:0]  r2_wxx, r2_wyy, r2_exx, r2_eyy;
    logic        [R2W-1:0] r2_r2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_dxx  <= PW'(r1_dx) * PW'(r1_dx);
            r2_dyy  <= PW'(r1_dy) * PW'(r1_dy);
            r2_wxdx <= PW'(r1_wx) * PW'(r1_dx);
            r2_wydy <= PW'(r1_wy) * PW'(r1_dy);
            r2_wxdy <= PW'(r1_wx) * PW'(r1_dy);
            r2_wydx <= PW'(r1_wy) * PW'(r1_dx);
            r2_wxx  <= PW'(r1_wx) * PW'(r1_wx);
            r2_wyy  <= PW'(r1_wy) * PW'(r1_wy);
            r2_exx  <= PW'(r1_ex) * PW'(r1_ex);
            r2_eyy  <= PW'(r1_ey) * PW'(r1_ey);
            r2_r2   <= R2W'(r1_r) * R2W'(r1_r);
        end
    end

    // Stage 3: squared lengths, projection (dot product) and cross product.
    logic        [MW-1:0]  r3_len2, r3_dw2, r3_de2;
    logic signed [SW-1:0]  r3_proj, r3_cross;
    logic        [R2W-1:0] r3_r2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_len2  <= $unsigned(r2_dxx) + $unsigned(r2_dyy);
            r3_dw2   <= $unsigned(r2_wxx) + $unsigned(r2_wyy);
            r3_de2   <= $unsigned(r2_exx) + $unsigned(r2_eyy);
            r3_proj  <= SW'(r2_wxdx) + SW'(r2_wydy);
            r3_cross <= SW'(r2_wxdy) - SW'(r2_wydx);
            r3_r2    <= r2_r2;
        end
    end

    // Stage 4: decide where the closest point lies. Behind the start point (or a
    // degenerate segment) checks the start; past the end checks the end; otherwise
    // the perpendicular distance decides, compared later in squared form.
    logic          n4_near_a, n4_far_b;
    logic [SW-1:0] n4_cr_abs;
    t_case         n4_case;

    always_comb begin
        n4_near_a = (r3_len2 == '0) || r3_proj[SW-1] || (r3_proj == '0);
        n4_far_b  = !r3_proj[SW-1] && ($unsigned(r3_proj) >= {1'b0, r3_len2});
        n4_case.interior = !n4_near_a && !n4_far_b;
        n4_case.end_hit  = n4_near_a ? (r3_dw2 <= MW'(r3_r2)) : (r3_de2 <= MW'(r3_r2));
        n4_cr_abs = r3_cross[SW-1] ? $unsigned(-r3_cross) : $unsigned(r3_cross);
    end

    t_case        r4_case;
    logic [K-1:0] r4_cr_hi, r4_cr_lo, r4_len_hi, r4_len_lo;
    logic [RW-1:0] r4_r2_hi, r4_r2_lo;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_case   <= n4_case;
            r4_cr_hi  <= n4_cr_abs[MW-1:K];
            r4_cr_lo  <= n4_cr_abs[K-1:0];
            r4_len_hi <= r3_len2[MW-1:K];
            r4_len_lo <= r3_len2[K-1:0];
            r4_r2_hi  <= r3_r2[R2W-1:RW];
            r4_r2_lo  <= r3_r2[RW-1:0];
        end
    end

    // Stage 5: partial products of cross^2 and r^2 * len^2.
    t_case          r5_case;
    logic [PPW-1:0] r5_c_hh, r5_c_hl, r5_c_ll;
    logic [RPW-1:0] r5_q_hh, r5_q_hl, r5_q_lh, r5_q_ll;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_case <= r4_case;
            r5_c_hh <= PPW'(r4_cr_hi) * PPW'(r4_cr_hi);
            r5_c_hl <= PPW'(r4_cr_hi) * PPW'(r4_cr_lo);
            r5_c_ll <= PPW'(r4_cr_lo) * PPW'(r4_cr_lo);
            r5_q_hh <= RPW'(r4_r2_hi) * RPW'(r4_len_hi);
            r5_q_hl <= RPW'(r4_r2_hi) * RPW'(r4_len_lo);
            r5_q_lh <= RPW'(r4_r2_lo) * RPW'(r4_len_hi);
            r5_q_ll <= RPW'(r4_r2_lo) * RPW'(r4_len_lo);
        end
    end

    // Stage 6: recombine the partial products into the two full squares.
    t_case         r6_case;
    logic [QW-1:0] r6_cross2, r6_rlen2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_case   <= r5_case;
            r6_cross2 <= (QW'(r5_c_hh) << (2 * K)) + (QW'(r5_c_hl) << (K + 1))
                       + QW'(r5_c_ll);
            r6_rlen2  <= (QW'(r5_q_hh) << (RW + K)) + (QW'(r5_q_hl) << RW)
                       + (QW'(r5_q_lh) << K) + QW'(r5_q_ll);
        end
    end

    // Stage 7: final answer into the output register.
    logic r7_hit;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_hit <= r6_case.interior ? (r6_cross2 <= r6_rlen2) : r6_case.end_hit;
        end
    end

    assign o_hit = r7_hit;

    // A degenerate segment never takes the perpendicular distance test.
    a_degenerate_not_interior : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_v[2] && (r3_len2 == '0) |=> !r4_case.interior)
        else $error("degenerate segment classified as interior");

    // A stalled pipeline keeps its valid bits and its result.
    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v) && $stable(r7_hit))
        else $error("pipeline moved during a stall");

    // An interior closest point implies a positive projection shorter than the segment.
    a_interior_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_v[2] && n4_case.interior |-> !r3_proj[SW-1] && (r3_proj != '0))
        else $error("interior case with projection outside the segment");

endmodule

/* tb/csit_hit_checker.sv */
// Checker for the circle versus segment intersection test: watches both channels,
// predicts each answer exactly in integer arithmetic and compares it in order.
// Depends on csit_pkg (coordinate width).
module csit_hit_checker
    import csit_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic signed [CSIT_COORD_BITS-1:0] i_center_x,
    input  logic signed [CSIT_COORD_BITS-1:0] i_center_y,
    input  logic        [CSIT_COORD_BITS-2:0] i_radius,
    input  logic signed [CSIT_COORD_BITS-1:0] i_start_x,
    input  logic signed [CSIT_COORD_BITS-1:0] i_start_y,
    input  logic signed [CSIT_COORD_BITS-1:0] i_end_x,
    input  logic signed [CSIT_COORD_BITS-1:0] i_end_y,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_hit,
    output int                                o_mismatches,
    output int                                o_queries_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted answers of the queries accepted so far, oldest first.
    bit pending_hits[$];
    int answers_seen;

    // Closed disc against closed segment. The closest point is found from the sign and
    // size of the projection; the interior case compares cross^2 with r^2 * |d|^2.
    function automatic bit disc_meets_segment(
        input logic signed [CSIT_COORD_BITS-1:0] cx, cy,
        input logic        [CSIT_COORD_BITS-2:0] r,
        input logic signed [CSIT_COORD_BITS-1:0] ax, ay, bx, by
    );
        longint      r2, dx, dy, wx, wy, len2, proj, cr;
        logic [127:0] cross_sq, bound;
        r2    = longint'(r) * longint'(r);
        dx    = longint'(bx) - longint'(ax);
        dy    = longint'(by) - longint'(ay);
        wx    = longint'(cx) - longint'(ax);
        wy    = longint'(cy) - longint'(ay);
        len2  = dx * dx + dy * dy;
        proj  = wx * dx + wy * dy;
        if (len2 == 0 || proj <= 0) begin
            return (wx * wx + wy * wy) <= r2;
        end else if (proj >= len2) begin
            return ((wx - dx) * (wx - dx) + (wy - dy) * (wy - dy)) <= r2;
        end
        cr = wx * dy - wy * dx;
        if (cr < 0) begin
            cr = -cr;
        end
        cross_sq = 128'(cr);
        cross_sq = cross_sq * cross_sq;
        bound    = 128'(r2);
        bound    = bound * 128'(len2);
        return cross_sq <= bound;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at answer %0d: %s", answers_seen, what);
        o_mismatches++;
    endtask

    initial begin
        o_mismatches        = 0;
        o_queries_in_flight = 0;
        answers_seen        = 0;
    end

    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (pending_hits.size() == 0) begin
                    flag_mismatch("answer beat with no query outstanding");
                end else begin
                    want = pending_hits.pop_front();
                    if (i_hit !== want) begin
                        flag_mismatch($sformatf("hit is %b, expected %b", i_hit, want));
                    end
                end
                answers_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                pending_hits.push_back(disc_meets_segment(i_center_x, i_center_y, i_radius,
                                                          i_start_x, i_start_y,
                                                          i_end_x, i_end_y));
            end
            o_queries_in_flight <= pending_hits.size();
        end
    end

endmodule

/* tb/tb_circle_segment_intersect_test_unit.sv */
// Top of the testbench for circle_segment_intersect_test_unit: clock, reset, stimulus
// and verdict. Depends on csit_pkg and on csit_hit_checker, which predicts and compares.
module tb_circle_segment_intersect_test_unit
    import csit_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB        = CSIT_COORD_BITS;
    localparam int COORD_MIN = -(1 << (CB - 1));
    localparam int COORD_MAX = (1 << (CB - 1)) - 1;
    localparam int RAD_MAX   = (1 << (CB - 1)) - 1;
    localparam int N_RANDOM  = 900;
    // Meant as the last stretch with no idling; as idling is switched every 100 beats, only the last 100 run so.
    localparam int N_CALM    = 150;
    // Watchdog limit on the number of clock edges of the whole run.
    localparam int CYCLE_LIMIT = 400000;
    // Pipeline depth is seven stages; the tail gives it plenty of room to drain.
    localparam int TAIL_CYCLES = 30;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic signed [CB-1:0] i_center_x  = '0;
    logic signed [CB-1:0] i_center_y  = '0;
    logic        [CB-2:0] i_radius    = '0;
    logic signed [CB-1:0] i_start_x   = '0;
    logic signed [CB-1:0] i_start_y   = '0;
    logic signed [CB-1:0] i_end_x     = '0;
    logic signed [CB-1:0] i_end_y     = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_hit;

    int mismatches;
    int queries_in_flight;
    int cycles = 0;

    // Idling switches for each side; the stimulus turns them on and off in stretches.
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    int stall_left     = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    circle_segment_intersect_test_unit #(
        .COORD_BITS (CB)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius    (i_radius),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_hit       (o_hit)
    );

    csit_hit_checker hit_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_center_x          (i_center_x),
        .i_center_y          (i_center_y),
        .i_radius            (i_radius),
        .i_start_x           (i_start_x),
        .i_start_y           (i_start_y),
        .i_end_x             (i_end_x),
        .i_end_y             (i_end_y),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_hit               (o_hit),
        .o_mismatches        (mismatches),
        .o_queries_in_flight (queries_in_flight)
    );

    // The receiver stalls in random bursts while idling is allowed.
    // A burst in progress is finished even if idling is switched off meanwhile, which
    // only delays the answers a little.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 18);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: a run that hangs ends here with the fail verdict.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[circle_segment_intersect_test_unit] ERROR");
        $finish;
    end

    function automatic int clip_coord(input int v);
        if (v < COORD_MIN) begin
            return COORD_MIN;
        end else if (v > COORD_MAX) begin
            return COORD_MAX;
        end
        return v;
    endfunction

    function automatic int clip_radius(input int v);
        if (v < 0) begin
            return 0;
        end else if (v > RAD_MAX) begin
            return RAD_MAX;
        end
        return v;
    endfunction

    // Uniform random coordinate over the whole signed range.
    function automatic int rand_coord();
        return int'($urandom_range(0, (1 << CB) - 1)) + COORD_MIN;
    endfunction

    // Symmetric random offset in [-lim, lim].
    function automatic int jitter(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // Presents one query beat and holds it until the block takes it. The call starts
    // and ends just after a rising edge, so back to back beats keep valid high with a
    // single assignment per edge; an idle gap lowers valid in a step of its own.
    task automatic send_query(
        input int cx, cy,
        input int r,
        input int ax, ay, bx, by
    );
        if (sender_idles && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_center_x <= CB'(cx);
        i_center_y <= CB'(cy);
        i_radius   <= (CB-1)'(r);
        i_start_x  <= CB'(ax);
        i_start_y  <= CB'(ay);
        i_end_x    <= CB'(bx);
        i_end_y    <= CB'(by);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    initial begin
        int kind, ccx, ccy, rr, ax, ay, bx, by, span, gap;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Extremes of every field first: the full coordinate range with
        // zero and largest radius, which also drives the widest internal products.
        send_query(COORD_MIN, COORD_MIN, 0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_query(COORD_MAX, COORD_MAX, RAD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_query(COORD_MIN, COORD_MAX, RAD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_query(COORD_MIN, COORD_MIN, RAD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN);
        send_query(COORD_MAX, COORD_MIN, RAD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_query(0, 0, RAD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_query(-1, -1, RAD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        // A degenerate segment collapses to a point test: inside, exactly on, outside.
        send_query(0, 0, 5, 1, 2, 1, 2);
        send_query(0, 0, 5, 3, 4, 3, 4);
        send_query(0, 0, 5, 4, 4, 4, 4);
        // An end point exactly on the circle, with the rest of the segment outside, decided
        // by the start point branch; then a segment ending on the circle whose closest point lies inside it.
        send_query(0, 0, 5, 5, 0, 100, 0);
        send_query(0, 0, 5, 100, 0, -3, -4);
        // Tangent line exactly at the radius, then one unit short of touching.
        send_query(0, 0, 5, -10, 5, 10, 5);
        send_query(0, 0, 4, -10, 5, 10, 5);
        send_query(7, -3, 13, -100, -16, 100, -16);
        // Zero radius: center on the segment, at an end point, and just off it.
        send_query(0, 0, 0, -10, 0, 10, 0);
        send_query(10, 0, 0, -10, 0, 10, 0);
        send_query(0, 1, 0, -10, 0, 10, 0);
        send_query(3, 3, 0, -6, -6, 9, 9);
        // Closest point behind the start, beyond the end, and inside the segment.
        send_query(-50, 0, 20, 0, 0, 100, 0);
        send_query(150, 0, 20, 0, 0, 100, 0);
        send_query(50, 30, 20, 0, 0, 100, 0);
        send_query(50, 20, 20, 0, 0, 100, 0);

        // Random part. Idling on either side is switched in stretches of 100 beats,
        // and the final stretch runs with no idling at all.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) begin
                sender_idles   = (n < N_RANDOM - N_CALM) && ($urandom_range(0, 3) != 0);
                receiver_idles = (n < N_RANDOM - N_CALM) && ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 99);
            ccx  = rand_coord();
            ccy  = rand_coord();
            rr   = $urandom_range(0, RAD_MAX);
            if (kind < 25) begin
                // Raw random bits in every field.
                ax = rand_coord();
                ay = rand_coord();
                bx = rand_coord();
                by = rand_coord();
            end else if (kind < 60) begin
                // End points scattered around the circle at about its own scale, so
                // hits and misses are balanced and all three branches are taken.
                rr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, RAD_MAX)
                                                 : $urandom_range(0, 300);
                span = 2 * rr + 4;
                ax = ccx + jitter(span);
                ay = ccy + jitter(span);
                bx = ccx + jitter(span);
                by = ccy + jitter(span);
            end else if (kind < 80) begin
                // Axis aligned segment at a distance of the radius plus -1, 0 or +1,
                // which probes the tangent boundary.
                rr   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 200)
                                                   : $urandom_range(0, RAD_MAX);
                gap  = rr + jitter(1);
                span = $urandom_range(1, 2 * rr + 8);
                if ($urandom_range(0, 1) == 0) begin
                    gap = -gap;
                end
                if ($urandom_range(0, 1) == 0) begin
                    ax = ccx - span + jitter(span / 2);
                    bx = ccx + span + jitter(span / 2);
                    ay = ccy + gap;
                    by = ay;
                end else begin
                    ay = ccy - span + jitter(span / 2);
                    by = ccy + span + jitter(span / 2);
                    ax = ccx + gap;
                    bx = ax;
                end
                if ($urandom_range(0, 1) == 0) begin
                    {ax, ay, bx, by} = {bx, by, ax, ay};
                end
            end else if (kind < 92) begin
                // Degenerate segment near the circle edge.
                rr = $urandom_range(0, 500);
                ax = ccx + jitter(rr + 2);
                ay = ccy + jitter(rr + 2);
                bx = ax;
                by = ay;
            end else begin
                // Corners of the coordinate range.
                ccx = ($urandom_range(0, 1) == 0) ? COORD_MIN : COORD_MAX;
                ccy = ($urandom_range(0, 1) == 0) ? COORD_MIN : COORD_MAX;
                ax  = ($urandom_range(0, 1) == 0) ? COORD_MIN : COORD_MAX;
                ay  = ($urandom_range(0, 1) == 0) ? COORD_MIN : COORD_MAX;
                bx  = ($urandom_range(0, 2) == 0) ? rand_coord() : COORD_MAX;
                by  = ($urandom_range(0, 2) == 0) ? rand_coord() : COORD_MIN;
                rr  = ($urandom_range(0, 1) == 0) ? RAD_MAX : $urandom_range(0, RAD_MAX);
            end
            send_query(clip_coord(ccx), clip_coord(ccy), clip_radius(rr),
                       clip_coord(ax), clip_coord(ay), clip_coord(bx), clip_coord(by));
        end
        i_in_valid <= 1'b0;

        // The checker counts the last beat at the edge that accepted it, so look again at the
        // next edge, then wait for every answer and let the pipeline drain.
        @(posedge i_clk);
        while (queries_in_flight != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[circle_segment_intersect_test_unit] OK");
        end else begin
            $display("[circle_segment_intersect_test_unit] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/csit_pkg.sv
hdl/circle_segment_intersect_test_unit.sv
tb/csit_hit_checker.sv
tb/tb_circle_segment_intersect_test_unit.sv
